// File: src/fpr_pkg.sv
`timescale 1ns / 1ps

package fpr_pkg;

  localparam int unsigned PAGES_DEF  = 16;
  localparam int unsigned FRAMES_DEF = 8;

  localparam logic [3:0] FRAME_COUNT_RST = 4'd3;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_LOOK  = 4'b0010,
    S_EVICT = 4'b0100,
    S_DONE  = 4'b1000
  } state_e;

  typedef struct packed {
    logic        fault;
    logic [2:0]  frame;
    logic        ev_valid;
    logic [3:0]  ev_page;
    logic [15:0] fault_count;
    logic        bad;
  } result_t;

endpackage

// File: src/fifo_page_replacement.sv
`timescale 1ns / 1ps
// Channel    Dir  Handshake                        Payload
// s_axis     in   s_axis_tvalid_i / s_axis_tready_o  tdata[3:0] page
// m_axis     out  m_axis_tvalid_o / m_axis_tready_i  tdata: fault, frame, evicted_valid,
//                                                    evicted_page, fault_count; tuser: bad_page
// cfg        in   cfg_we_i                          cfg_wdata_i[3:0] frame_count
//
// One item at a time: a hit, a bad page or a miss into a free frame is read, updated
// and handed to output; an eviction adds a step, since the victim's frame needs a
// second read of the page-frame RAM, whose address comes from the queue read.
// Reset clears the valid and occupancy flops, queue pointers and fault count at once.
// The output register holds a result while the next item is read and updated;
// the block waits in its final step only when that register is still full.

module fifo_page_replacement #(
  parameter int unsigned PAGES  = fpr_pkg::PAGES_DEF,
  parameter int unsigned FRAMES = fpr_pkg::FRAMES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [3:0] page
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [0] fault, [3:1] frame, [4] evicted_valid, [8:5] evicted_page, [24:9] fault_count
  output logic [31:0] m_axis_tdata_o,
  output logic        m_axis_tuser_o,   // [0] bad_page
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i
);

  localparam int unsigned PAW = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int unsigned FW  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned LW  = $clog2(FRAMES + 1);

  fpr_pkg::state_e  state_q, state_d;
  logic [3:0]       page_q, page_d;
  logic [3:0]       victim_q, victim_d;
  logic [PAGES-1:0] page_valid_q, page_valid_d;
  logic [FRAMES-1:0] frame_used_q, frame_used_d;
  logic [FW-1:0]    head_q, head_d;
  logic [LW-1:0]    fill_q, fill_d;
  logic [15:0]      faults_q, faults_d;
  logic [3:0]       fc_q;
  fpr_pkg::result_t res_q, res_d;
  fpr_pkg::result_t out_q, out_d;
  logic             out_valid_q, out_valid_d;

  logic             pt_we, pt_re;
  logic [PAW-1:0]   pt_waddr, pt_raddr;
  logic [FW-1:0]    pt_wdata, pt_rdata;
  logic             fq_we, fq_re;
  logic [FW-1:0]    fq_waddr, fq_raddr;
  logic [3:0]       fq_wdata, fq_rdata;

  logic [LW-1:0]    eff_frames;
  logic             free_found;
  logic [FW-1:0]    free_idx;
  logic [FW:0]      wp_sum;
  logic [FW-1:0]    wp;
  logic [PAW-1:0]   page_addr;
  logic [PAW-1:0]   victim_addr;
  logic             accept;

  fpr_ram #(.WIDTH(FW), .DEPTH(PAGES)) u_page_frame (
    .clk_i   (clk_i),
    .we_i    (pt_we),
    .waddr_i (pt_waddr),
    .wdata_i (pt_wdata),
    .re_i    (pt_re),
    .raddr_i (pt_raddr),
    .rdata_o (pt_rdata)
  );

  fpr_ram #(.WIDTH(4), .DEPTH(FRAMES)) u_fifo_pages (
    .clk_i   (clk_i),
    .we_i    (fq_we),
    .waddr_i (fq_waddr),
    .wdata_i (fq_wdata),
    .re_i    (fq_re),
    .raddr_i (fq_raddr),
    .rdata_o (fq_rdata)
  );

  // Clamp the frame count into 1..FRAMES.
  always_comb begin
    if (fc_q == 4'd0) begin
      eff_frames = LW'(1);
    end else if (32'(fc_q) > FRAMES) begin
      eff_frames = LW'(FRAMES);
    end else begin
      eff_frames = LW'(fc_q);
    end
  end

  // Lowest free frame below the effective count.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if (!frame_used_q[i] && (i < int'(eff_frames))) begin
        free_found = 1'b1;
        free_idx   = FW'(i);
      end
    end
  end

  // Tail slot of the queue: (head + fill) mod FRAMES, with fill at most FRAMES.
  assign wp_sum = (FW + 1)'(head_q) + (FW + 1)'(fill_q);
  assign wp     = (wp_sum >= (FW + 1)'(FRAMES)) ? FW'(wp_sum - (FW + 1)'(FRAMES)) : FW'(wp_sum);

  assign page_addr   = PAW'(page_q);
  assign victim_addr = PAW'(victim_q);
  assign accept      = s_axis_tvalid_i && s_axis_tready_o;

  assign s_axis_tready_o = (state_q == fpr_pkg::S_IDLE);

  always_comb begin
    state_d      = state_q;
    page_d       = page_q;
    victim_d     = victim_q;
    page_valid_d = page_valid_q;
    frame_used_d = frame_used_q;
    head_d       = head_q;
    fill_d       = fill_q;
    faults_d     = faults_q;
    res_d        = res_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && !m_axis_tready_i;

    pt_re    = 1'b0;
    pt_raddr = PAW'(s_axis_tdata_i[3:0]);
    pt_we    = 1'b0;
    pt_waddr = page_addr;
    pt_wdata = free_idx;
    fq_re    = 1'b0;
    fq_raddr = head_q;
    fq_we    = 1'b0;
    fq_waddr = wp;
    fq_wdata = page_q;

    unique case (state_q)
      fpr_pkg::S_IDLE: begin
        if (accept) begin
          pt_re   = 1'b1;
          fq_re   = 1'b1;
          page_d  = s_axis_tdata_i[3:0];
          state_d = fpr_pkg::S_LOOK;
        end
      end

      fpr_pkg::S_LOOK: begin
        res_d             = '0;
        res_d.fault_count = faults_q;
        state_d           = fpr_pkg::S_DONE;
        if (32'(page_q) >= PAGES) begin
          res_d.bad = 1'b1;
        end else if (page_valid_q[page_addr]) begin
          res_d.frame = 3'(pt_rdata);
        end else begin
          if (faults_q != 16'hFFFF) begin
            faults_d = faults_q + 16'd1;
          end
          res_d.fault       = 1'b1;
          res_d.fault_count = faults_d;
          if (free_found) begin
            frame_used_d[free_idx]  = 1'b1;
            page_valid_d[page_addr] = 1'b1;
            pt_we                   = 1'b1;
            res_d.frame             = 3'(free_idx);
            if (32'(fill_q) < FRAMES) begin
              fq_we  = 1'b1;
              fill_d = fill_q + LW'(1);
            end
          end else if (fill_q != '0) begin
            // Fetch the oldest page's frame for reuse.
            victim_d = fq_rdata;
            pt_re    = 1'b1;
            pt_raddr = PAW'(fq_rdata);
            state_d  = fpr_pkg::S_EVICT;
          end
        end
      end

      fpr_pkg::S_EVICT: begin
        // Pop the head and push the new page; fill is unchanged.
        head_d                    = (head_q == FW'(FRAMES - 1)) ? '0 : head_q + FW'(1);
        page_valid_d[victim_addr] = 1'b0;
        page_valid_d[page_addr]   = 1'b1;
        pt_we                     = 1'b1;
        pt_wdata                  = pt_rdata;
        fq_we                     = 1'b1;
        res_d                     = '0;
        res_d.fault               = 1'b1;
        res_d.frame               = 3'(pt_rdata);
        res_d.ev_valid            = 1'b1;
        res_d.ev_page             = victim_q;
        res_d.fault_count         = faults_q;
        state_d                   = fpr_pkg::S_DONE;
      end

      fpr_pkg::S_DONE: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = fpr_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = fpr_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= fpr_pkg::S_IDLE;
      page_valid_q <= '0;
      frame_used_q <= '0;
      head_q       <= '0;
      fill_q       <= '0;
      faults_q     <= '0;
      fc_q         <= fpr_pkg::FRAME_COUNT_RST;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      page_valid_q <= page_valid_d;
      frame_used_q <= frame_used_d;
      head_q       <= head_d;
      fill_q       <= fill_d;
      faults_q     <= faults_d;
      out_valid_q  <= out_valid_d;
      if (cfg_we_i) begin
        fc_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    page_q   <= page_d;
    victim_q <= victim_d;
    res_q    <= res_d;
    out_q    <= out_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'd0, out_q.fault_count, out_q.ev_page, out_q.ev_valid,
                            out_q.frame, out_q.fault};
  assign m_axis_tuser_o  = out_q.bad;

  // An eviction only happens on a fault.
  a_evict_is_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[4]) |-> m_axis_tdata_o[0])
    else $error("eviction reported without a fault");

  // A bad page never faults.
  a_bad_no_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> !m_axis_tdata_o[0])
    else $error("bad page reported as a fault");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fill_q) <= FRAMES)
    else $error("queue fill exceeds frame count");

  a_faults_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (faults_q >= $past(faults_q)))
    else $error("fault counter decreased");

endmodule

// File: src/fpr_ram.sv
`timescale 1ns / 1ps

module fpr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned NPAGES  = fpr_pkg::PAGES_DEF;
  localparam int unsigned NFRAMES = fpr_pkg::FRAMES_DEF;
  localparam int unsigned RANDOM_ITEMS = 800;
  localparam int unsigned TAIL_ITEMS = 48;
  localparam int unsigned SCRIPT_LEN = 30;

  typedef enum bit {ROW_PAGE, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e        kind;
    logic [3:0]       value;   // page, or frame_count for ROW_CFG
    logic             typed;   // compare against want instead of the predictor
    fpr_pkg::result_t want;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic [7:0]  s_data = '0;
  logic        m_ready = 1'b0;
  logic        cfg_we = 1'b0;
  logic [3:0]  cfg_wdata = '0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [31:0] m_axis_tdata_o;
  logic        m_axis_tuser_o;

  // Predictor state: page table, frame occupancy, load-order queue
  bit          res_valid [NPAGES];
  bit [2:0]    res_frame [NPAGES];
  bit          frame_busy [NFRAMES];
  bit [3:0]    load_order [NFRAMES];
  int unsigned order_head = 0;
  int unsigned order_fill = 0;
  bit [15:0]   fault_total = '0;
  bit [3:0]    frames_cfg = fpr_pkg::FRAME_COUNT_RST;

  fpr_pkg::result_t expected_outcomes [$];
  bit          idle_on = 1'b1;
  int unsigned ready_left = 0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned faults_seen = 0;
  int unsigned settings_used = 0;
  int unsigned mismatches = 0;

  row_t script [SCRIPT_LEN] = '{
    '{ROW_PAGE, 4'd0,  1'b1, '{1'b1, 3'd0, 1'b0, 4'd0,  16'd1, 1'b0}},
    '{ROW_PAGE, 4'd0,  1'b1, '{1'b0, 3'd0, 1'b0, 4'd0,  16'd1, 1'b0}},
    '{ROW_PAGE, 4'd15, 1'b1, '{1'b1, 3'd1, 1'b0, 4'd0,  16'd2, 1'b0}},
    '{ROW_PAGE, 4'd7,  1'b1, '{1'b1, 3'd2, 1'b0, 4'd0,  16'd3, 1'b0}},
    '{ROW_PAGE, 4'd9,  1'b1, '{1'b1, 3'd0, 1'b1, 4'd0,  16'd4, 1'b0}},
    '{ROW_PAGE, 4'd0,  1'b1, '{1'b1, 3'd1, 1'b1, 4'd15, 16'd5, 1'b0}},
    '{ROW_PAGE, 4'd9,  1'b1, '{1'b0, 3'd0, 1'b0, 4'd0,  16'd5, 1'b0}},
    // zero frames acts as one; resident pages above frame 0 stay put
    '{ROW_CFG,  4'd0,  1'b0, '0},
    '{ROW_PAGE, 4'd5,  1'b0, '0},
    '{ROW_PAGE, 4'd6,  1'b0, '0},
    '{ROW_PAGE, 4'd0,  1'b0, '0},
    // above the frame total acts as the full set
    '{ROW_CFG,  4'd15, 1'b0, '0},
    '{ROW_PAGE, 4'd1,  1'b0, '0},
    '{ROW_PAGE, 4'd2,  1'b0, '0},
    '{ROW_PAGE, 4'd3,  1'b0, '0},
    '{ROW_PAGE, 4'd8,  1'b0, '0},
    '{ROW_PAGE, 4'd10, 1'b0, '0},
    '{ROW_PAGE, 4'd11, 1'b0, '0},
    '{ROW_CFG,  4'd8,  1'b0, '0},
    '{ROW_PAGE, 4'd12, 1'b0, '0},
    '{ROW_PAGE, 4'd13, 1'b0, '0},
    '{ROW_PAGE, 4'd14, 1'b0, '0},
    '{ROW_PAGE, 4'd6,  1'b0, '0},
    // shrink while full: evicted high frames get reused
    '{ROW_CFG,  4'd1,  1'b0, '0},
    '{ROW_PAGE, 4'd15, 1'b0, '0},
    '{ROW_PAGE, 4'd15, 1'b0, '0},
    '{ROW_PAGE, 4'd0,  1'b0, '0},
    '{ROW_CFG,  4'd2,  1'b0, '0},
    '{ROW_PAGE, 4'd4,  1'b0, '0},
    '{ROW_PAGE, 4'd11, 1'b0, '0}
  };

  fifo_page_replacement dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata)
  );

  always #6 clk_i = ~clk_i;

  function automatic fpr_pkg::result_t fifo_replace_lookup(input logic [3:0] pg);
    fpr_pkg::result_t r;
    int unsigned lim, i;
    bit [3:0]    victim;
    bit          found, placed;
    r = '0;
    found = 1'b0;
    placed = 1'b0;
    if (pg >= NPAGES) begin
      r.bad = 1'b1;
    end else if (res_valid[pg]) begin
      r.frame = res_frame[pg];
    end else begin
      r.fault = 1'b1;
      if (fault_total != 16'hFFFF) fault_total++;
      lim = (frames_cfg == 0) ? 1 : (frames_cfg > NFRAMES) ? NFRAMES : frames_cfg;
      for (i = 0; i < lim; i++) begin
        if (!found && !frame_busy[i]) begin
          found = 1'b1;
          r.frame = i[2:0];
        end
      end
      if (found) begin
        frame_busy[r.frame] = 1'b1;
        placed = 1'b1;
      end else if (order_fill > 0) begin
        // evict the oldest resident page and take over its frame
        victim = load_order[order_head];
        order_head = (order_head + 1) % NFRAMES;
        order_fill--;
        r.frame = res_frame[victim];
        res_valid[victim] = 1'b0;
        r.ev_valid = 1'b1;
        r.ev_page = victim;
        placed = 1'b1;
      end
      if (placed) begin
        res_frame[pg] = r.frame;
        res_valid[pg] = 1'b1;
        if (order_fill < NFRAMES) begin
          load_order[(order_head + order_fill) % NFRAMES] = pg;
          order_fill++;
        end
      end
    end
    r.fault_count = fault_total;
    return r;
  endfunction

  task automatic log_mismatch(input string msg);
    $display("[%0t] mismatch at result %0d: %s", $realtime, results_seen, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned want);
    if (got != want) log_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  task automatic send_page(input logic [3:0] pg, input bit typed,
                           input fpr_pkg::result_t want);
    fpr_pkg::result_t predicted;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= {4'b0000, pg};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    predicted = fifo_replace_lookup(pg);
    expected_outcomes.push_back(typed ? want : predicted);
    items_sent++;
  endtask

  // Drain the block before touching frame_count
  task automatic write_frame_count(input logic [3:0] value);
    s_valid <= 1'b0;
    while (expected_outcomes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    frames_cfg = value;
    settings_used++;
  endtask

  // Receiver: alternate ready bursts and stall bursts, or stay ready while idle_on is clear
  always @(posedge clk_i) begin
    if (!idle_on) begin
      m_ready <= 1'b1;
      ready_left <= 0;
    end else if (ready_left != 0) begin
      ready_left <= ready_left - 1;
    end else if ($urandom_range(0, 2) == 0) begin
      m_ready <= 1'b0;
      ready_left <= $urandom_range(0, 17);
    end else begin
      m_ready <= 1'b1;
      ready_left <= $urandom_range(0, 30);
    end
  end

  always @(posedge clk_i) begin
    fpr_pkg::result_t got, want;
    if (rst_ni && m_axis_tvalid_o && m_ready) begin
      got.fault       = m_axis_tdata_o[0];
      got.frame       = m_axis_tdata_o[3:1];
      got.ev_valid    = m_axis_tdata_o[4];
      got.ev_page     = m_axis_tdata_o[8:5];
      got.fault_count = m_axis_tdata_o[24:9];
      got.bad         = m_axis_tuser_o;
      if (expected_outcomes.size() == 0) begin
        log_mismatch("result with nothing outstanding");
      end else begin
        want = expected_outcomes.pop_front();
        check_field("fault", got.fault, want.fault);
        check_field("frame", got.frame, want.frame);
        check_field("evicted_valid", got.ev_valid, want.ev_valid);
        check_field("evicted_page", got.ev_page, want.ev_page);
        check_field("fault_count", got.fault_count, want.fault_count);
        check_field("bad_page", got.bad, want.bad);
        if (want.fault) faults_seen++;
      end
      results_seen++;
    end
  end

  initial begin
    #(50_000_000);
    $display("timeout: block stopped delivering results");
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int unsigned n, ws, base, tail, w;
    logic [3:0]  pg;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[i]) begin
      if (script[i].kind == ROW_CFG) write_frame_count(script[i].value);
      else send_page(script[i].value, script[i].typed, script[i].want);
    end

    // Random phases: a random frame count and a working set of up to twelve pages, with some
    // references spread over the whole table
    while (items_sent < SCRIPT_LEN + RANDOM_ITEMS) begin
      write_frame_count(($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                                    : 4'($urandom_range(1, 8)));
      idle_on = ($urandom_range(0, 3) != 0);
      n = $urandom_range(40, 110);
      ws = $urandom_range(1, 11);
      base = $urandom_range(0, 15 - ws);
      repeat (n) begin
        if ($urandom_range(0, 4) == 0) pg = 4'($urandom_range(0, 15));
        else pg = 4'(base + $urandom_range(0, ws));
        send_page(pg, 1'b0, '0);
      end
    end

    // Cycle through every page with the frame count at one, so references
    // fault and evict, back to back
    write_frame_count(4'd1);
    idle_on = 1'b0;
    pg = '0;
    for (tail = 0; tail < TAIL_ITEMS; tail++) begin
      send_page(pg, 1'b0, '0);
      pg++;
    end
    s_valid <= 1'b0;

    for (w = 0; w < 2000 && expected_outcomes.size() != 0; w++) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (expected_outcomes.size() != 0)
      log_mismatch($sformatf("%0d results never arrived", expected_outcomes.size()));

    $display("Checked %0d results from %0d page references over %0d frame-count writes",
             results_seen, items_sent, settings_used);
    $display("Faults predicted along the way: %0d, final counter value %0d",
             faults_seen, fault_total);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
